>>> design/polynomial_value_and_slope_unit_assert.svh
// Assertion macros shared by the polynomial value and slope unit RTL.
`ifndef POLYNOMIAL_VALUE_AND_SLOPE_UNIT_ASSERT_SVH
`define POLYNOMIAL_VALUE_AND_SLOPE_UNIT_ASSERT_SVH

// Clocked check on clk, off while rst is high.
`define PVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, written as condition and consequence.
`define PVS_ASSERT_IMPLY(lbl, pre, post, msg) \
  `PVS_ASSERT(lbl, (pre) |-> (post), msg)

`endif

>>> design/pvs_pkg.sv
// Shared constants, types and register codes of the polynomial value and slope unit.
`default_nettype none

package pvs_pkg;

  localparam int MAX_TERMS = 6;
  localparam int COEF_REGS = 6;
  localparam int STEPS     = MAX_TERMS - 1;

  localparam int SAMPLE_W  = 32;
  localparam int FRAC_W    = 16;
  localparam int VAL_W     = 48;
  localparam int ACTIVE_W  = 3;
  localparam int TERM_W    = $clog2(MAX_TERMS + 1);
  localparam int SCOEF_W   = SAMPLE_W + $clog2(MAX_TERMS);

  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;

  localparam logic [ACTIVE_W-1:0] ACTIVE_TERMS_RESET = ACTIVE_W'(MAX_TERMS);

  localparam logic signed [VAL_W-1:0] Q48_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] Q48_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ACTIVE_TERMS = 3'd0,
    REG_COEF_0       = 3'd1,
    REG_COEF_1       = 3'd2,
    REG_COEF_2       = 3'd3,
    REG_COEF_3       = 3'd4,
    REG_COEF_4       = 3'd5,
    REG_COEF_5       = 3'd6
  } pvs_reg_t;

  // Per-item payload carried down the Horner pipeline.
  typedef struct packed {
    logic [SAMPLE_W-1:0]     s_mag;
    logic                    s_neg;
    logic                    ovf;
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] slope;
  } pvs_data_t;

  typedef struct packed {
    logic      valid;
    pvs_data_t data;
  } pvs_stage_t;

endpackage

`default_nettype wire

>>> design/pvs_if.sv
// Stream channel interfaces: sample input and result output.
`default_nettype none

interface pvs_sample_if import pvs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_point;

  modport source(output valid, output sample_point, input ready);
  modport sink(input valid, input sample_point, output ready);
endinterface

interface pvs_result_if import pvs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] poly_value;
  logic signed [VAL_W-1:0] poly_slope;
  logic                    overflow;

  modport source(output valid, output poly_value, output poly_slope, output overflow,
                 input ready);
  modport sink(input valid, input poly_value, input poly_slope, input overflow,
               output ready);
endinterface

`default_nettype wire

>>> design/pvs_cfg_regs.sv
// APB register file: term count and coefficients, plus derived slope coefficients.
`default_nettype none

module pvs_cfg_regs import pvs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready,
  output logic [TERM_W-1:0]          n_terms,
  output logic signed [SAMPLE_W-1:0] coef [MAX_TERMS],
  output logic signed [SCOEF_W-1:0]  scaled [MAX_TERMS]
);

  logic [ACTIVE_W-1:0]  active_terms;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr      = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_terms <= ACTIVE_TERMS_RESET;
      for (int j = 0; j < MAX_TERMS; j++) begin
        coef[j] <= '0;
      end
    end else if (wr) begin
      case (pvs_reg_t'(reg_idx))
        REG_ACTIVE_TERMS: begin
          active_terms <= pwdata[ACTIVE_W-1:0];
        end
        default: begin
          for (int j = 0; j < MAX_TERMS; j++) begin
            if (j < COEF_REGS &&
                reg_idx == REG_IDX_W'(REG_COEF_0) + REG_IDX_W'(j)) begin
              coef[j] <= pwdata[SAMPLE_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (pvs_reg_t'(reg_idx))
      REG_ACTIVE_TERMS: begin
        prdata = APB_DW'(active_terms);
      end
      default: begin
        for (int j = 0; j < MAX_TERMS; j++) begin
          if (j < COEF_REGS &&
              reg_idx == REG_IDX_W'(REG_COEF_0) + REG_IDX_W'(j)) begin
            prdata = APB_DW'(coef[j]);
          end
        end
      end
    endcase
  end

  // Term counts above the supported maximum clamp to it.
  assign n_terms = (int'(active_terms) > MAX_TERMS) ? TERM_W'(MAX_TERMS)
                                                     : TERM_W'(active_terms);

  // j * c_j feeds the derivative Horner chain; constant multiplies.
  always_comb begin
    for (int j = 0; j < MAX_TERMS; j++) begin
      scaled[j] = SCOEF_W'(coef[j]) * SCOEF_W'(j);
    end
  end

endmodule

`default_nettype wire

>>> design/pvs_horner_step.sv
// One Horner step for value and slope lanes, four register stages deep.
`default_nettype none
`include "polynomial_value_and_slope_unit_assert.svh"

module pvs_horner_step import pvs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       val_active,
  input  logic                       slope_active,
  input  logic signed [SAMPLE_W-1:0] coef_val,
  input  logic signed [SCOEF_W-1:0]  coef_slope,
  input  pvs_stage_t                 st_in,
  output pvs_stage_t                 st_out
);

  localparam int LO_W  = SAMPLE_W;
  localparam int HI_W  = VAL_W - LO_W;
  localparam int PLO_W = LO_W + SAMPLE_W;
  localparam int PHI_W = HI_W + SAMPLE_W;
  localparam int M_W   = VAL_W + SAMPLE_W - FRAC_W - 1;
  localparam int SUM_W = M_W + 2;
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (FRAC_W - 1);

  typedef struct packed {
    pvs_data_t        d;
    logic [VAL_W-1:0] v_mag;
    logic             v_neg;
    logic [VAL_W-1:0] sl_mag;
    logic             sl_neg;
  } step_a_t;

  typedef struct packed {
    pvs_data_t        d;
    logic [PLO_W-1:0] v_plo;
    logic [PHI_W-1:0] v_phi;
    logic             v_neg;
    logic [PLO_W-1:0] sl_plo;
    logic [PHI_W-1:0] sl_phi;
    logic             sl_neg;
  } step_b_t;

  typedef struct packed {
    pvs_data_t      d;
    logic [M_W-1:0] v_m;
    logic           v_neg;
    logic [M_W-1:0] sl_m;
    logic           sl_neg;
  } step_c_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] val;
  } sat_t;

  function automatic sat_t sat48(input logic signed [SUM_W-1:0] x);
    sat_t r;
    r.hit = (x[SUM_W-1:VAL_W-1] != {(SUM_W-VAL_W+1){x[SUM_W-1]}});
    r.val = r.hit ? (x[SUM_W-1] ? Q48_MIN : Q48_MAX) : x[VAL_W-1:0];
    return r;
  endfunction

  logic      a_valid, b_valid, c_valid, d_valid;
  step_a_t   a, a_next;
  step_b_t   b, b_next;
  step_c_t   c, c_next;
  pvs_data_t d, d_next;

  logic [SUM_W-1:0]        v_wide, sl_wide;
  logic signed [SUM_W-1:0] cx_v, mx_v, sum_v, cx_s, mx_s, sum_s;
  sat_t                    v_sat, s_sat;

  // Stage A: sign-magnitude split of both accumulators.
  always_comb begin
    a_next.d      = st_in.data;
    a_next.v_mag  = st_in.data.val[VAL_W-1] ? VAL_W'(~st_in.data.val + 1'b1)
                                            : VAL_W'(st_in.data.val);
    a_next.v_neg  = st_in.data.val[VAL_W-1] ^ st_in.data.s_neg;
    a_next.sl_mag = st_in.data.slope[VAL_W-1] ? VAL_W'(~st_in.data.slope + 1'b1)
                                              : VAL_W'(st_in.data.slope);
    a_next.sl_neg = st_in.data.slope[VAL_W-1] ^ st_in.data.s_neg;
  end

  // Stage B: magnitude times |s| as two partial products per lane.
  always_comb begin
    b_next.d      = a.d;
    b_next.v_neg  = a.v_neg;
    b_next.sl_neg = a.sl_neg;
    b_next.v_plo  = PLO_W'(a.v_mag[LO_W-1:0]) * PLO_W'(a.d.s_mag);
    b_next.v_phi  = PHI_W'(a.v_mag[VAL_W-1:LO_W]) * PHI_W'(a.d.s_mag);
    b_next.sl_plo = PLO_W'(a.sl_mag[LO_W-1:0]) * PLO_W'(a.d.s_mag);
    b_next.sl_phi = PHI_W'(a.sl_mag[VAL_W-1:LO_W]) * PHI_W'(a.d.s_mag);
  end

  // Stage C: merge partials, round half up on the magnitude, drop fraction bits.
  always_comb begin
    v_wide  = ((SUM_W'(b.v_plo) + RND) >> FRAC_W) + (SUM_W'(b.v_phi) << (LO_W - FRAC_W));
    sl_wide = ((SUM_W'(b.sl_plo) + RND) >> FRAC_W) + (SUM_W'(b.sl_phi) << (LO_W - FRAC_W));
    c_next.d      = b.d;
    c_next.v_neg  = b.v_neg;
    c_next.sl_neg = b.sl_neg;
    c_next.v_m    = v_wide[M_W-1:0];
    c_next.sl_m   = sl_wide[M_W-1:0];
  end

  // Stage D: apply sign, add coefficient, clamp to 48 bits.
  always_comb begin
    cx_v  = SUM_W'(coef_val);
    mx_v  = SUM_W'(c.v_m);
    sum_v = c.v_neg ? (cx_v - mx_v) : (cx_v + mx_v);
    cx_s  = SUM_W'(coef_slope);
    mx_s  = SUM_W'(c.sl_m);
    sum_s = c.sl_neg ? (cx_s - mx_s) : (cx_s + mx_s);
    v_sat = sat48(sum_v);
    s_sat = sat48(sum_s);

    d_next       = c.d;
    d_next.val   = val_active ? v_sat.val : c.d.val;
    d_next.slope = slope_active ? s_sat.val : c.d.slope;
    d_next.ovf   = c.d.ovf | (val_active & v_sat.hit) | (slope_active & s_sat.hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      a_valid <= st_in.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a <= a_next;
      b <= b_next;
      c <= c_next;
      d <= d_next;
    end
  end

  assign st_out.valid = d_valid;
  assign st_out.data  = d;

  // History of advance cycles, used by the checks below.
  logic [3:0] run_hist, vskip_hist, sskip_hist;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_hist   <= '0;
      vskip_hist <= '0;
      sskip_hist <= '0;
    end else begin
      run_hist   <= {run_hist[2:0], en};
      vskip_hist <= {vskip_hist[2:0], en & ~val_active};
      sskip_hist <= {sskip_hist[2:0], en & ~slope_active};
    end
  end

  // Only live transactions are compared; bubbles carry unknown data.
  `PVS_ASSERT_IMPLY(a_smag_align, st_out.valid && &run_hist, st_out.data.s_mag == $past(st_in.data.s_mag, 4), "s misaligned")
  `PVS_ASSERT_IMPLY(a_ovf_sticky, st_out.valid && &run_hist && $past(st_in.data.ovf, 4), st_out.data.ovf, "ovf lost")
  `PVS_ASSERT_IMPLY(a_val_skip, st_out.valid && &vskip_hist, st_out.data.val == $past(st_in.data.val, 4), "val skip")
  `PVS_ASSERT_IMPLY(a_slope_skip, st_out.valid && &sskip_hist, st_out.data.slope == $past(st_in.data.slope, 4), "slope skip")

endmodule

`default_nettype wire

>>> design/polynomial_value_and_slope_unit.sv
// Throughput: one sample per cycle when not stalled; each Horner step is a fixed
// four-stage slice (abs, split multiply, round, add and clamp), skipped steps pass data through.
// Output backpressure stalls the whole pipeline in place; nothing is dropped or repeated.
// Reset: pipeline valid bits clear, active_terms returns to 6, all coefficients to 0.
`default_nettype none

module polynomial_value_and_slope_unit import pvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  pvs_sample_if.sink         samples,
  pvs_result_if.source       results
);

  logic [TERM_W-1:0]          n_terms;
  logic signed [SAMPLE_W-1:0] coef [MAX_TERMS];
  logic signed [SCOEF_W-1:0]  scaled [MAX_TERMS];

  pvs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .n_terms (n_terms),
    .coef    (coef),
    .scaled  (scaled)
  );

  logic       en;
  pvs_stage_t st [STEPS+1];

  assign en            = ~st[STEPS].valid | results.ready;
  assign samples.ready = en;

  // Entry stage: |s| and the leading coefficient of each Horner chain.
  logic                    e_valid;
  pvs_data_t               e_data, e_data_next;
  logic signed [VAL_W-1:0] val_init, slope_init;

  always_comb begin
    val_init   = '0;
    slope_init = '0;
    for (int j = 0; j < MAX_TERMS; j++) begin
      if (n_terms == TERM_W'(j + 1)) begin
        val_init   = VAL_W'(coef[j]);
        slope_init = VAL_W'(scaled[j]);
      end
    end
    e_data_next.s_neg = samples.sample_point[SAMPLE_W-1];
    e_data_next.s_mag = samples.sample_point[SAMPLE_W-1]
                        ? SAMPLE_W'(~samples.sample_point + 1'b1)
                        : SAMPLE_W'(samples.sample_point);
    e_data_next.ovf   = 1'b0;
    e_data_next.val   = val_init;
    e_data_next.slope = slope_init;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_data <= e_data_next;
    end
  end

  assign st[0].valid = e_valid;
  assign st[0].data  = e_data;

  // Step k handles coefficient index MAX_TERMS-2-k, highest first.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int J = MAX_TERMS - 2 - k;

    pvs_horner_step u_step (
      .clk          (clk),
      .rst          (rst),
      .en           (en),
      .val_active   (n_terms > TERM_W'(J + 1)),
      .slope_active ((J >= 1) && (n_terms > TERM_W'(J + 1))),
      .coef_val     (coef[J]),
      .coef_slope   (scaled[J]),
      .st_in        (st[k]),
      .st_out       (st[k+1])
    );
  end

  assign results.valid      = st[STEPS].valid;
  assign results.poly_value = st[STEPS].data.val;
  assign results.poly_slope = st[STEPS].data.slope;
  assign results.overflow   = st[STEPS].data.ovf;

endmodule

`default_nettype wire
